>>> hw/rtl/left_to_right_expression_evaluator_macros.svh
// assertion macros for the evaluator rtl
// no dependencies; included by files that carry assertions
`ifndef LEFT_TO_RIGHT_EXPRESSION_EVALUATOR_MACROS_SVH
`define LEFT_TO_RIGHT_EXPRESSION_EVALUATOR_MACROS_SVH

// same-cycle implication
`define LTR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LTR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ltr_eval_pkg.sv
// types and constants for the left-to-right expression evaluator
// no dependencies
`timescale 1ns / 1ps

package ltr_eval_pkg;

  localparam int DATA_W = 32;
  localparam int NUM_W  = 31;
  localparam int CNT_W  = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);
  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_NINE  = 8'h39;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_STAR  = 8'h2A;
  localparam logic [7:0] SYM_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctrl_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_stat_t;

endpackage

>>> hw/rtl/ltr_eval_if.sv
// request and result channels of the evaluator
// depends on nothing; payload widths fixed by the channel fields
`timescale 1ns / 1ps

interface ltr_eval_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] symbol;

  modport source (output valid, output operation, output symbol, input ready);
  modport sink (input valid, input operation, input symbol, output ready);
endinterface

interface ltr_eval_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] total;
  logic               divide_error;

  modport source (output valid, output total, output divide_error, input ready);
  modport sink (input valid, input total, input divide_error, output ready);
endinterface

>>> hw/rtl/ltr_eval_alu.sv
// iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide
// depends on ltr_eval_pkg
`timescale 1ns / 1ps

module ltr_eval_alu
  import ltr_eval_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  alu_ctrl_t         ctrl,
  input  logic [DATA_W-1:0] a,
  input  logic [NUM_W-1:0]  b,
  output logic [DATA_W-1:0] result,
  output alu_stat_t         stat
);

  typedef enum logic [1:0] {S_IDLE, S_ITER, S_FIN} state_t;

  state_t            state;
  op_t               op_q;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] sh;
  logic [DATA_W-1:0] opnd;
  logic              neg;
  logic [DATA_W-1:0] b_ext;
  logic [DATA_W:0]   trial;
  alu_stat_t         stat_next;

  assign b_ext = {1'b0, b};
  // one restoring step: bring down the next dividend bit
  assign trial = {acc, sh[DATA_W-1]} - {1'b0, opnd};

  // done pulses after a start of add, subtract, none or a divide by zero, or when the shift loop ends
  always_comb begin
    stat_next = '0;
    unique case (state)
      S_IDLE: begin
        if (ctrl.start) begin
          case (ctrl.op)
            OP_MUL: stat_next.done = 1'b0;
            OP_DIV: begin
              stat_next.done     = (b == '0);
              stat_next.div_zero = (b == '0);
            end
            default: stat_next.done = 1'b1;
          endcase
        end
      end
      S_ITER: stat_next = '0;
      S_FIN: stat_next.done = 1'b1;
      default: stat_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stat  <= '0;
    end else begin
      stat <= stat_next;
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            op_q <= ctrl.op;
            cnt  <= '0;
            case (ctrl.op)
              OP_ADD: begin
                result <= a + b_ext;
              end
              OP_SUB: begin
                result <= a - b_ext;
              end
              OP_MUL: begin
                acc   <= '0;
                sh    <= a;
                opnd  <= b_ext;
                state <= S_ITER;
              end
              OP_DIV: begin
                if (b == '0) begin
                  result <= '0;
                end else begin
                  acc   <= '0;
                  sh    <= a[DATA_W-1] ? ('0 - a) : a;
                  neg   <= a[DATA_W-1];
                  opnd  <= b_ext;
                  state <= S_ITER;
                end
              end
              default: begin
                result <= b_ext;
              end
            endcase
          end
        end
        S_ITER: begin
          cnt <= cnt + 1'b1;
          if (op_q == OP_DIV) begin
            if (!trial[DATA_W]) begin
              acc <= trial[DATA_W-1:0];
              sh  <= {sh[DATA_W-2:0], 1'b1};
            end else begin
              acc <= {acc[DATA_W-2:0], sh[DATA_W-1]};
              sh  <= {sh[DATA_W-2:0], 1'b0};
            end
          end else begin
            acc  <= acc + (opnd[0] ? sh : '0);
            sh   <= {sh[DATA_W-2:0], 1'b0};
            opnd <= {1'b0, opnd[DATA_W-1:1]};
          end
          if (cnt == CNT_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (op_q == OP_MUL) begin
            result <= acc;
          end else begin
            result <= neg ? ('0 - sh) : sh;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/left_to_right_expression_evaluator.sv
// channel   | dir | fields                          | meaning
// req       | in  | operation[0], symbol[7:0]       | one character or a finish request
// rsp       | out | total[31:0] signed, divide_error| evaluated expression
//
// a digit or an ignored character is taken in ST_IDLE, which it does not leave
// an operator starts the pending operation in ltr_eval_alu and waits in ST_WAIT for its done;
// none, + or -, or a divide by zero is done from the alu's idle state, a * or / after the 32-step shift loop
// a finish request runs the pending operation the same way, then loads rsp in ST_EMIT
// rst is synchronous and clears the total, number, pending operation and error flag
// a finish waits while the result register still holds an untaken result
// depends on ltr_eval_pkg, ltr_eval_if, ltr_eval_alu and the macros header
`timescale 1ns / 1ps
`include "left_to_right_expression_evaluator_macros.svh"

module left_to_right_expression_evaluator
  import ltr_eval_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  ltr_eval_req_if.sink          req,
  ltr_eval_rsp_if.source        rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_EMIT} state_t;

  state_t             state;
  logic [DATA_W-1:0]  total;
  logic [NUM_W-1:0]   number;
  op_t                pending;
  op_t                next_op;
  logic               err;
  logic               finishing;
  logic               rsp_valid;
  logic signed [DATA_W-1:0] rsp_total;
  logic               rsp_err;

  logic               accept;
  logic               is_digit;
  logic               is_op;
  op_t                sym_op;
  logic [NUM_W+3:0]   num_wide;
  logic [NUM_W-1:0]   num_next;

  alu_ctrl_t          alu_ctrl;
  alu_stat_t          alu_stat;
  logic [DATA_W-1:0]  alu_result;

  assign req.ready        = (state == ST_IDLE);
  assign accept           = req.valid && req.ready;
  assign rsp.valid        = rsp_valid;
  assign rsp.total        = rsp_total;
  assign rsp.divide_error = rsp_err;

  assign is_digit = (req.symbol >= SYM_ZERO) && (req.symbol <= SYM_NINE);

  always_comb begin
    sym_op = OP_NONE;
    is_op  = 1'b1;
    unique case (req.symbol)
      SYM_PLUS:  sym_op = OP_ADD;
      SYM_MINUS: sym_op = OP_SUB;
      SYM_STAR:  sym_op = OP_MUL;
      SYM_SLASH: sym_op = OP_DIV;
      default:   is_op  = 1'b0;
    endcase
  end

  // number * 10 + digit, saturating
  assign num_wide = {1'b0, number, 3'b000} + {3'b000, number, 1'b0}
                  + {{NUM_W{1'b0}}, req.symbol[3:0]};
  assign num_next = (num_wide > {4'b0000, NUM_MAX}) ? NUM_MAX : num_wide[NUM_W-1:0];

  assign alu_ctrl.start = accept && (req.operation || (!is_digit && is_op));
  assign alu_ctrl.op    = pending;

  ltr_eval_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (alu_ctrl),
    .a      (total),
    .b      (number),
    .result (alu_result),
    .stat   (alu_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      total     <= '0;
      number    <= '0;
      pending   <= OP_NONE;
      next_op   <= OP_NONE;
      err       <= 1'b0;
      finishing <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // emit handles the result register itself
      if (rsp_valid && rsp.ready && (state != ST_EMIT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.operation) begin
              finishing <= 1'b1;
              state     <= ST_WAIT;
            end else if (is_digit) begin
              number <= num_next;
            end else if (is_op) begin
              finishing <= 1'b0;
              next_op   <= sym_op;
              state     <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (alu_stat.done) begin
            total <= alu_result;
            err   <= err | alu_stat.div_zero;
            if (finishing) begin
              state <= ST_EMIT;
            end else begin
              pending <= next_op;
              number  <= '0;
              state   <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_total <= total;
            rsp_err   <= err;
            total     <= '0;
            number    <= '0;
            pending   <= OP_NONE;
            err       <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LTR_ASSERT_IMP(a_rsp_from_emit, clk, rst, $rose(rsp_valid), $past(state == ST_EMIT), "result loaded outside emit")
  `LTR_ASSERT_NEXT(a_number_held, clk, rst, (state == ST_WAIT) && !alu_stat.done, $stable(number), "number changed while alu busy")
  `LTR_ASSERT_NEXT(a_done_pulse, clk, rst, alu_stat.done, !alu_stat.done, "alu done longer than one cycle")
  `LTR_ASSERT_IMP(a_err_source, clk, rst, $rose(err), $past(alu_stat.div_zero), "error flag set without divide by zero")

endmodule
